FILE: hdl/bmbd_pkg.sv
// ----------------------------------------------------------------------------
// bmbd_pkg
// Types and fixed constants of the banked memory bus decoder.
// ----------------------------------------------------------------------------
package bmbd_pkg;

   // Where a decoded access lands
   typedef enum logic [2:0] {
      TGT_NONE,
      TGT_MAIN,
      TGT_BANK,
      TGT_HANDLER,
      TGT_ROM,
      TGT_KEY_FLAG,
      TGT_KEY,
      TGT_AUDIO
   } target_type;

   localparam logic [15:0] TOP_PAGE      = 16'hFF00;
   localparam logic [15:0] ROM_BYTES     = 16'h0F00;
   localparam logic [7:0]  HANDLER_BANKS = 8'd6;
   localparam int          HND_DEPTH     = 1536;
   localparam int          HND_AW        = 11;
   localparam int          AUDIO_REGS    = 5;
   localparam logic [15:0] AUDIO_FIRST   = 16'd1;
   localparam logic [15:0] AUDIO_LAST    = 16'd5;
   localparam logic [2:0]  AUD_RESET     = 3'd0;
   localparam logic [2:0]  AUD_OSC       = 3'd1;
   localparam logic [2:0]  AUD_REG       = 3'd2;
   localparam logic [2:0]  AUD_DATA      = 3'd3;
   localparam logic [2:0]  AUD_DIR       = 3'd4;
   localparam logic [7:0]  BANK_ROM      = 8'd0;
   localparam logic [7:0]  BANK_KEYS     = 8'd1;
   localparam logic [7:0]  BANK_AUDIO    = 8'd3;
   localparam logic [7:0]  ROM_BYTE0     = 8'hDB;
   localparam logic [7:0]  ROM_BYTE1     = 8'h02;

   // Boot ROM contents: two leading bytes, zero elsewhere
   function automatic logic [7:0] rom_byte(input logic [15:0] off);
      logic [7:0] val;
      val = 8'h00;
      if (off < ROM_BYTES) begin
         if (off == 16'd0) begin
            val = ROM_BYTE0;
         end else if (off == 16'd1) begin
            val = ROM_BYTE1;
         end
      end
      return val;
   endfunction

endpackage

FILE: hdl/bmbd_if.sv
// ----------------------------------------------------------------------------
// bmbd_req_if / bmbd_rsp_if
// Valid/ready channels carrying bus accesses and their results.
// ----------------------------------------------------------------------------
interface bmbd_req_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [15:0] address;
   logic [7:0]  write_byte;

   modport source (output valid, kind, address, write_byte, input ready);
   modport sink   (input valid, kind, address, write_byte, output ready);
endinterface

interface bmbd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] read_byte;
   logic [7:0] bank_now;
   logic       audio_reset_pin;
   logic [7:0] audio_osc_pin;
   logic [7:0] audio_reg_pin;
   logic [7:0] audio_data_pin;
   logic [7:0] audio_dir_pin;

   modport source (output valid, read_byte, bank_now, audio_reset_pin, audio_osc_pin,
                   audio_reg_pin, audio_data_pin, audio_dir_pin, input ready);
   modport sink   (input valid, read_byte, bank_now, audio_reset_pin, audio_osc_pin,
                   audio_reg_pin, audio_data_pin, audio_dir_pin, output ready);
endinterface

FILE: hdl/banked_memory_bus_decoder.sv
// Path: an accepted item passes the execute stage, then the result register driving rsp.
// Throughput: one item per cycle while results drain; set by the single
// read-modify-write stage behind the registered memory read.
// Reset: control flops, bank, key flag, audio registers and bus value clear at once;
// key table reads zero through per-entry valid bits; main and handler RAMs are not cleared.
// ----------------------------------------------------------------------------
// banked_memory_bus_decoder
// Decodes CPU bus accesses onto main RAM, bank register, handler RAMs,
// boot ROM, keyboard state and audio registers.
// ----------------------------------------------------------------------------
module banked_memory_bus_decoder #(
   parameter int WINDOW_BASE = 32768,
   parameter int KEY_COUNT   = 57
) (
   input logic        clock,
   input logic        reset,
   bmbd_req_if.sink   req_ch,
   bmbd_rsp_if.source rsp_ch
);
   import bmbd_pkg::*;

   localparam int          MAIN_DEPTH = WINDOW_BASE - 1;
   localparam int          MAIN_AW    = $clog2(MAIN_DEPTH);
   localparam int          KEY_DEPTH  = KEY_COUNT + 1;
   localparam int          KEY_AW     = $clog2(KEY_DEPTH);
   localparam logic [15:0] WIN_BASE   = 16'(WINDOW_BASE);
   localparam logic [15:0] BANK_ADDR  = 16'(WINDOW_BASE - 1);
   localparam logic [15:0] KEY_LAST   = 16'(KEY_COUNT);

   // storage
   logic [7:0]           main_mem [MAIN_DEPTH];
   logic [7:0]           hnd_mem  [HND_DEPTH];
   logic [7:0]           key_mem  [KEY_DEPTH];
   logic [KEY_DEPTH-1:0] key_valid_ff;
   logic [7:0]           main_q_ff, hnd_q_ff, key_q_ff;

   logic [7:0] bank_ff, bank_in;
   logic [7:0] key_flag_ff, key_flag_in;
   logic [7:0] audio_ff [AUDIO_REGS];
   logic [7:0] audio_in [AUDIO_REGS];
   logic [7:0] bus_hold_ff, bus_in;

   // execute stage
   logic              exec_valid_ff;
   target_type        tgt_ff, tgt_in;
   logic              kind_ff;
   logic [15:0]       addr_ff;
   logic [7:0]        wb_ff;
   logic [2:0]        hbank_ff, hbank_in;
   logic              fwd_hit_ff, fwd_hit_in;
   logic [7:0]        fwd_data_ff;

   // result register
   logic rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_read_ff, rsp_bank_ff;
   logic [7:0] rsp_audio_ff [AUDIO_REGS];

   logic              req_fire, exec_fire, exec_write;
   logic [7:0]        bank_eff;
   logic [15:0]       off_req, off_ex;
   logic [2:0]        aud_idx;
   logic [KEY_AW-1:0] key_idx_ex;
   logic [HND_AW-1:0] hnd_idx_req, hnd_idx_ex;
   logic [7:0]        stored;

   assign exec_fire  = exec_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign exec_write = exec_fire && !kind_ff;
   assign req_ch.ready = !exec_valid_ff || exec_fire;
   assign req_fire   = req_ch.valid && req_ch.ready;

   // ---------------- decode on accept ----------------
   // take the bank written by the item finishing in this cycle
   assign bank_eff    = (exec_write && tgt_ff == TGT_BANK) ? wb_ff : bank_ff;
   assign off_req     = req_ch.address - WIN_BASE;
   assign hbank_in    = 3'(bank_eff - 8'd1);
   assign hnd_idx_req = {hbank_in, req_ch.address[7:0]};

   always_comb begin
      tgt_in = TGT_NONE;
      if (req_ch.address < BANK_ADDR) begin
         tgt_in = TGT_MAIN;
      end else if (req_ch.address == BANK_ADDR) begin
         tgt_in = TGT_BANK;
      end else if (req_ch.address >= TOP_PAGE) begin
         if (bank_eff >= 8'd1 && bank_eff <= HANDLER_BANKS) begin
            tgt_in = TGT_HANDLER;
         end
      end else if (bank_eff == BANK_ROM) begin
         tgt_in = TGT_ROM;
      end else if (bank_eff == BANK_KEYS) begin
         if (off_req == 16'd0) begin
            tgt_in = TGT_KEY_FLAG;
         end else if (off_req <= KEY_LAST) begin
            tgt_in = TGT_KEY;
         end
      end else if (bank_eff == BANK_AUDIO) begin
         if (off_req >= AUDIO_FIRST && off_req <= AUDIO_LAST) begin
            tgt_in = TGT_AUDIO;
         end
      end
   end

   // forward a memory write that lands in the same cycle as this item's read
   always_comb begin
      fwd_hit_in = exec_write && tgt_ff == tgt_in && addr_ff == req_ch.address &&
                   (tgt_ff == TGT_MAIN || tgt_ff == TGT_HANDLER || tgt_ff == TGT_KEY) &&
                   (tgt_in != TGT_HANDLER || hbank_ff == hbank_in);
   end

   // ---------------- execute ----------------
   assign off_ex     = addr_ff - WIN_BASE;
   assign aud_idx    = off_ex[2:0] - 3'd1;
   assign key_idx_ex = off_ex[KEY_AW-1:0];
   assign hnd_idx_ex = {hbank_ff, addr_ff[7:0]};

   always_comb begin
      case (tgt_ff)
         TGT_MAIN:     stored = main_q_ff;
         TGT_HANDLER:  stored = hnd_q_ff;
         TGT_KEY:      stored = key_valid_ff[key_idx_ex] ? key_q_ff : 8'h00;
         TGT_KEY_FLAG: stored = key_flag_ff;
         TGT_BANK:     stored = bank_ff;
         TGT_AUDIO:    stored = audio_ff[aud_idx];
         default:      stored = 8'h00;
      endcase
      if (fwd_hit_ff) begin
         stored = fwd_data_ff;
      end
   end

   always_comb begin
      case (tgt_ff)
         TGT_ROM:  bus_in = rom_byte(off_ex);
         TGT_NONE: bus_in = kind_ff ? bus_hold_ff : wb_ff;
         default:  bus_in = kind_ff ? stored : wb_ff;
      endcase
   end

   always_comb begin
      bank_in     = bank_ff;
      key_flag_in = key_flag_ff;
      for (int i = 0; i < AUDIO_REGS; i++) begin
         audio_in[i] = audio_ff[i];
      end
      if (exec_write) begin
         case (tgt_ff)
            TGT_BANK:     bank_in = wb_ff;
            TGT_KEY_FLAG: key_flag_in = wb_ff;
            TGT_AUDIO: begin
               // reset line keeps only its low bit
               audio_in[aud_idx] = (aud_idx == AUD_RESET) ? {7'd0, wb_ff[0]} : wb_ff;
            end
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid_in = exec_fire || (rsp_valid_ff && !rsp_ch.ready);

   // ---------------- memories ----------------
   always_ff @(posedge clock) begin
      if (req_fire && tgt_in == TGT_MAIN) begin
         main_q_ff <= main_mem[req_ch.address[MAIN_AW-1:0]];
      end
      if (exec_write && tgt_ff == TGT_MAIN) begin
         main_mem[addr_ff[MAIN_AW-1:0]] <= wb_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && tgt_in == TGT_HANDLER) begin
         hnd_q_ff <= hnd_mem[hnd_idx_req];
      end
      if (exec_write && tgt_ff == TGT_HANDLER) begin
         hnd_mem[hnd_idx_ex] <= wb_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && tgt_in == TGT_KEY) begin
         key_q_ff <= key_mem[off_req[KEY_AW-1:0]];
      end
      if (exec_write && tgt_ff == TGT_KEY) begin
         key_mem[key_idx_ex] <= wb_ff;
      end
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         exec_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         key_valid_ff  <= '0;
         bank_ff       <= 8'h00;
         key_flag_ff   <= 8'h00;
         bus_hold_ff   <= 8'h00;
         for (int i = 0; i < AUDIO_REGS; i++) begin
            audio_ff[i] <= 8'h00;
         end
      end else begin
         exec_valid_ff <= req_fire || (exec_valid_ff && !exec_fire);
         rsp_valid_ff  <= rsp_valid_in;
         bank_ff       <= bank_in;
         key_flag_ff   <= key_flag_in;
         for (int i = 0; i < AUDIO_REGS; i++) begin
            audio_ff[i] <= audio_in[i];
         end
         if (exec_fire) begin
            bus_hold_ff <= bus_in;
         end
         if (exec_write && tgt_ff == TGT_KEY) begin
            key_valid_ff[key_idx_ex] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         tgt_ff      <= tgt_in;
         kind_ff     <= req_ch.kind;
         addr_ff     <= req_ch.address;
         wb_ff       <= req_ch.write_byte;
         hbank_ff    <= hbank_in;
         fwd_hit_ff  <= fwd_hit_in;
         fwd_data_ff <= wb_ff;
      end
      if (exec_fire) begin
         rsp_read_ff <= bus_in;
         rsp_bank_ff <= bank_in;
         for (int i = 0; i < AUDIO_REGS; i++) begin
            rsp_audio_ff[i] <= audio_in[i];
         end
      end
   end

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.read_byte       = rsp_read_ff;
   assign rsp_ch.bank_now        = rsp_bank_ff;
   assign rsp_ch.audio_reset_pin = rsp_audio_ff[AUD_RESET][0];
   assign rsp_ch.audio_osc_pin   = rsp_audio_ff[AUD_OSC];
   assign rsp_ch.audio_reg_pin   = rsp_audio_ff[AUD_REG];
   assign rsp_ch.audio_data_pin  = rsp_audio_ff[AUD_DATA];
   assign rsp_ch.audio_dir_pin   = rsp_audio_ff[AUD_DIR];

   // ---------------- checks ----------------
   a_accept_loads_exec: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> exec_valid_ff)
      else $error("accepted item did not reach execute stage");

   a_exec_gives_result: assert property (@(posedge clock) disable iff (reset)
      exec_fire |=> rsp_valid_ff)
      else $error("finished item produced no result");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ch.ready) |-> !exec_fire)
      else $error("pending result overwritten");

   a_reset_line_bit: assert property (@(posedge clock) disable iff (reset)
      audio_ff[AUD_RESET][7:1] == 7'd0)
      else $error("audio reset register holds upper bits");

   a_bank_write: assert property (@(posedge clock) disable iff (reset)
      (exec_write && tgt_ff == TGT_BANK) |=> bank_ff == $past(wb_ff))
      else $error("bank register write lost");

endmodule

FILE: tb/sv/tb_banked_memory_bus_decoder.sv
// ----------------------------------------------------------------------------
// tb_banked_memory_bus_decoder
// Drives CPU bus accesses into the decoder: a directed pass over the memory map
// edges, then bank-switch runs with random content and noise. A scoreboard
// tracks bank, RAMs, keys and audio state and checks every result in order.
// ----------------------------------------------------------------------------
module tb_banked_memory_bus_decoder;
   timeunit 1ns;
   timeprecision 1ps;

   import bmbd_pkg::*;

   localparam int          WINDOW_BASE  = 32768;
   localparam int          KEY_COUNT    = 57;
   localparam int          RANDOM_ITEMS = 950;
   localparam int          MAX_REPORTS  = 10;
   localparam logic [15:0] WIN_START    = 16'(WINDOW_BASE);
   localparam logic [15:0] BANK_ADDR    = WIN_START - 16'd1;

   typedef enum logic {
      ACC_WRITE = 1'b0,
      ACC_READ  = 1'b1
   } access_kind_type;

   typedef struct packed {
      access_kind_type kind;
      logic [15:0]     address;
      logic [7:0]      write_byte;
   } bus_access_type;

   typedef struct packed {
      logic [7:0] read_byte;
      logic [7:0] bank_now;
      logic       audio_reset_pin;
      logic [7:0] audio_osc_pin;
      logic [7:0] audio_reg_pin;
      logic [7:0] audio_data_pin;
      logic [7:0] audio_dir_pin;
   } bus_result_type;

   class bus_map_scoreboard;
      bit [7:0]       bank_reg;
      bit [7:0]       bus_hold;
      bit [7:0]       key_flag;
      bit [7:0]       key_state [KEY_COUNT + 1];
      bit [7:0]       audio [AUDIO_REGS];
      bit [7:0]       main_mem [WINDOW_BASE - 1];
      bit             main_valid [WINDOW_BASE - 1];
      bit [7:0]       handler_mem [HND_DEPTH];
      bit             handler_valid [HND_DEPTH];
      bus_result_type expected_results [$];
      int             mismatches;

      function target_type locate(logic [15:0] addr);
         logic [15:0] off;
         target_type  tgt;
         off = addr - WIN_START;
         tgt = TGT_NONE;
         if (addr < BANK_ADDR) begin
            tgt = TGT_MAIN;
         end else if (addr == BANK_ADDR) begin
            tgt = TGT_BANK;
         end else if (addr >= TOP_PAGE) begin
            if (bank_reg >= 8'd1 && bank_reg <= HANDLER_BANKS) tgt = TGT_HANDLER;
         end else begin
            case (bank_reg)
               BANK_ROM: begin
                  tgt = TGT_ROM;
               end
               BANK_KEYS: begin
                  if (off == 16'd0) tgt = TGT_KEY_FLAG;
                  else if (off <= KEY_COUNT) tgt = TGT_KEY;
               end
               BANK_AUDIO: begin
                  if (off >= AUDIO_FIRST && off <= AUDIO_LAST) tgt = TGT_AUDIO;
               end
               default: ;
            endcase
         end
         return tgt;
      endfunction

      function int handler_index(logic [15:0] addr);
         return (int'(bank_reg) - 1) * 256 + int'(addr[7:0]);
      endfunction

      // Reads of RAM bytes that were never written are off limits
      function bit read_allowed(bus_access_type acc);
         if (acc.kind != ACC_READ) return 1'b1;
         case (locate(acc.address))
            TGT_MAIN:    return main_valid[acc.address];
            TGT_HANDLER: return handler_valid[handler_index(acc.address)];
            default:     return 1'b1;
         endcase
      endfunction

      function void note_access(bus_access_type acc);
         logic [7:0]     bus;
         logic [15:0]    off;
         bit             rd;
         int             idx;
         bus_result_type res;
         rd  = (acc.kind == ACC_READ);
         bus = rd ? bus_hold : acc.write_byte;
         off = acc.address - WIN_START;
         case (locate(acc.address))
            TGT_MAIN: begin
               if (rd) begin
                  bus = main_mem[acc.address];
               end else begin
                  main_mem[acc.address]   = acc.write_byte;
                  main_valid[acc.address] = 1'b1;
               end
            end
            TGT_BANK: begin
               if (rd) bus = bank_reg;
               else bank_reg = acc.write_byte;
            end
            TGT_HANDLER: begin
               idx = handler_index(acc.address);
               if (rd) begin
                  bus = handler_mem[idx];
               end else begin
                  handler_mem[idx]   = acc.write_byte;
                  handler_valid[idx] = 1'b1;
               end
            end
            TGT_ROM: begin
               // ROM wins the bus on reads and writes alike; zero past the boot bytes
               bus = 8'h00;
               if (off == 16'd0) bus = ROM_BYTE0;
               else if (off == 16'd1) bus = ROM_BYTE1;
            end
            TGT_KEY_FLAG: begin
               if (rd) bus = key_flag;
               else key_flag = acc.write_byte;
            end
            TGT_KEY: begin
               if (rd) bus = key_state[off];
               else key_state[off] = acc.write_byte;
            end
            TGT_AUDIO: begin
               idx = int'(off - AUDIO_FIRST);
               if (rd) begin
                  bus = audio[idx];
               end else if (idx == AUD_RESET) begin
                  audio[idx] = {7'd0, acc.write_byte[0]};
               end else begin
                  audio[idx] = acc.write_byte;
               end
            end
            default: ;
         endcase
         bus_hold            = bus;
         res.read_byte       = bus;
         res.bank_now        = bank_reg;
         res.audio_reset_pin = audio[AUD_RESET][0];
         res.audio_osc_pin   = audio[AUD_OSC];
         res.audio_reg_pin   = audio[AUD_REG];
         res.audio_data_pin  = audio[AUD_DATA];
         res.audio_dir_pin   = audio[AUD_DIR];
         expected_results.push_back(res);
      endfunction

      function void flag(string msg);
         mismatches++;
         if (mismatches <= MAX_REPORTS) $display("[%0t] %s", $realtime, msg);
      endfunction

      function void compare_field(string name, logic [7:0] want, logic [7:0] got);
         if (got !== want) begin
            flag($sformatf("%s mismatch: expected %02h, got %02h", name, want, got));
         end
      endfunction

      function void check_result(bus_result_type got);
         bus_result_type want;
         if (expected_results.size() == 0) begin
            flag("result arrived with no access outstanding");
            return;
         end
         want = expected_results.pop_front();
         compare_field("read_byte", want.read_byte, got.read_byte);
         compare_field("bank_now", want.bank_now, got.bank_now);
         compare_field("audio_reset_pin", {7'd0, want.audio_reset_pin},
                       {7'd0, got.audio_reset_pin});
         compare_field("audio_osc_pin", want.audio_osc_pin, got.audio_osc_pin);
         compare_field("audio_reg_pin", want.audio_reg_pin, got.audio_reg_pin);
         compare_field("audio_data_pin", want.audio_data_pin, got.audio_data_pin);
         compare_field("audio_dir_pin", want.audio_dir_pin, got.audio_dir_pin);
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   int unsigned       cycle_count = 0;
   wire               quiet_stretch = (cycle_count >= 400 && cycle_count < 800);
   bus_map_scoreboard sb = new;

   bmbd_req_if req_bus ();
   bmbd_rsp_if rsp_bus ();

   banked_memory_bus_decoder #(
      .WINDOW_BASE (WINDOW_BASE),
      .KEY_COUNT   (KEY_COUNT)
   ) u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            sb.note_access(bus_access_type'{access_kind_type'(req_bus.kind),
                                            req_bus.address, req_bus.write_byte});
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            sb.check_result(bus_result_type'{rsp_bus.read_byte, rsp_bus.bank_now,
                                             rsp_bus.audio_reset_pin, rsp_bus.audio_osc_pin,
                                             rsp_bus.audio_reg_pin, rsp_bus.audio_data_pin,
                                             rsp_bus.audio_dir_pin});
         end
      end
   end

   // Result side back-pressure
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_bus.ready <= quiet_stretch || ($urandom_range(99) >= 6);
      end
   end

   task automatic send_access(access_kind_type k, logic [15:0] a, logic [7:0] d);
      if (!quiet_stretch && $urandom_range(99) < 6) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.kind       <= k;
      req_bus.address    <= a;
      req_bus.write_byte <= d;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic logic [7:0] pick_bank();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 25) return BANK_ROM;
      if (r < 50) return BANK_KEYS;
      if (r < 75) return BANK_AUDIO;
      if (r < 92) return 8'($urandom_range(1, HANDLER_BANKS));
      return 8'($urandom);
   endfunction

   // Called only after the previous item is accepted, so the scoreboard state is current
   function automatic bus_access_type pick_access();
      bus_access_type acc;
      int unsigned    r;
      int unsigned    w;
      logic [15:0]    off;
      r              = $urandom_range(99);
      w              = $urandom_range(9);
      acc.kind       = access_kind_type'($urandom_range(1));
      acc.write_byte = 8'($urandom);
      if (r < 15) begin
         acc.address = 16'($urandom);
      end else if (r < 30) begin
         // small pool so reads find written bytes
         case ($urandom_range(7))
            0:       acc.address = 16'd0;
            1:       acc.address = BANK_ADDR - 16'd1;
            default: acc.address = 16'($urandom_range(31)) * 16'd1021;
         endcase
      end else if (r < 45) begin
         acc.address = TOP_PAGE + 16'($urandom_range(3) != 0 ? $urandom_range(15)
                                                             : $urandom_range(255));
      end else if (r < 52) begin
         acc.kind    = ACC_READ;
         acc.address = BANK_ADDR;
      end else begin
         if (w < 4) off = 16'($urandom_range(7));
         else if (w < 7) off = 16'($urandom_range(63));
         else if (w == 7) off = ROM_BYTES - 16'd2 + 16'($urandom_range(3));
         else off = 16'($urandom_range(TOP_PAGE - WIN_START - 16'd1));
         acc.address = WIN_START + off;
      end
      if (!sb.read_allowed(acc)) acc.kind = ACC_WRITE;
      return acc;
   endfunction

   initial begin
      bus_access_type acc;
      int             random_sent;
      int             run_len;
      req_bus.valid      = 1'b0;
      req_bus.kind       = 1'b0;
      req_bus.address    = 16'd0;
      req_bus.write_byte = 8'd0;
      random_sent        = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // boot ROM window, its end and unmapped top page at bank zero
      send_access(ACC_READ, WIN_START, 8'h00);
      send_access(ACC_READ, WIN_START + 16'd1, 8'h00);
      send_access(ACC_READ, WIN_START + ROM_BYTES - 16'd1, 8'h00);
      send_access(ACC_READ, WIN_START + ROM_BYTES, 8'h00);
      send_access(ACC_WRITE, WIN_START, 8'h55);
      send_access(ACC_WRITE, TOP_PAGE, 8'hA3);
      send_access(ACC_READ, 16'hFFFF, 8'h00);
      // main RAM ends
      send_access(ACC_WRITE, 16'd0, 8'hFF);
      send_access(ACC_WRITE, BANK_ADDR - 16'd1, 8'h00);
      send_access(ACC_READ, 16'd0, 8'h00);
      send_access(ACC_READ, BANK_ADDR - 16'd1, 8'h00);
      // keyboard bank: flag, last key, first offset past the keys
      send_access(ACC_WRITE, BANK_ADDR, BANK_KEYS);
      send_access(ACC_WRITE, WIN_START, 8'hA5);
      send_access(ACC_WRITE, WIN_START + 16'(KEY_COUNT), 8'h3C);
      send_access(ACC_READ, WIN_START + 16'(KEY_COUNT), 8'h00);
      send_access(ACC_READ, WIN_START + 16'(KEY_COUNT) + 16'd1, 8'h00);
      // audio bank: reset keeps bit 0 only
      send_access(ACC_WRITE, BANK_ADDR, BANK_AUDIO);
      send_access(ACC_WRITE, WIN_START + AUDIO_FIRST, 8'hFF);
      send_access(ACC_WRITE, WIN_START + AUDIO_LAST, 8'h81);
      send_access(ACC_READ, WIN_START + AUDIO_FIRST, 8'h00);
      send_access(ACC_WRITE, WIN_START + AUDIO_LAST + 16'd1, 8'h12);
      // last handler bank, then a bank with no handler
      send_access(ACC_WRITE, BANK_ADDR, HANDLER_BANKS);
      send_access(ACC_WRITE, 16'hFFFF, 8'h77);
      send_access(ACC_READ, 16'hFFFF, 8'h00);
      send_access(ACC_WRITE, BANK_ADDR, 8'hFF);
      send_access(ACC_READ, TOP_PAGE, 8'h00);
      send_access(ACC_READ, BANK_ADDR, 8'h00);

      // bank switch, then a run of accesses against that bank
      while (random_sent < RANDOM_ITEMS) begin
         send_access(ACC_WRITE, BANK_ADDR, pick_bank());
         run_len = $urandom_range(4, 12);
         repeat (run_len) begin
            acc = pick_access();
            send_access(acc.kind, acc.address, acc.write_byte);
         end
         random_sent += run_len + 1;
      end
      req_bus.valid <= 1'b0;

      while (sb.expected_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (sb.mismatches == 0 && sb.expected_results.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   initial begin
      #200000;
      $display("Regression FAIL");
      $finish;
   end

endmodule
